// ===== hw/rtl/on_off_pkg.sv =====
// ----------------------------------------------------------------------------
// on_off_pkg
// Shared constants for the on/off significance pipeline.
// ----------------------------------------------------------------------------
package on_off_pkg;

    localparam int RATIO_BITS = 24;
    localparam int SIG_BITS   = 32;

    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 24'd65536;

    // Two times the natural logarithm of two, with thirty fraction bits.
    localparam logic [30:0] TWO_LN2 = 31'd1488522236;

    typedef enum logic {
        STATUS_VALID = 1'b0,
        STATUS_EMPTY = 1'b1
    } t_status;

endpackage
// ----------------------------------------------------------------------------

// ===== hw/rtl/on_off_significance.sv =====
// ----------------------------------------------------------------------------
// on_off_significance
// Pipelined Li and Ma significance of an on/off counting measurement.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken on a rising edge with start high and busy low; busy is
// low at all times after the first cycle out of reset, so one item may be
// taken in every cycle. The result appears on o_significance and o_status
// for exactly one cycle, marked by o_valid, once the item has run through
// all pipeline registers, from the input register to the output register.
// LF = min(55 - COUNT_BITS, 30) is the number of fraction bits of the
// logarithm; the four logarithm units have LF squaring stages and the
// square root has 32 stages. Throughput is one item per cycle. The exposure
// ratio is written through the configuration channel, which is always
// ready; each transfer replaces the register. The user must see that it is
// written only while no item is in flight; the block does not enforce this.
// Reset empties the pipeline and restores a ratio of one. The receiver
// cannot stall the block: each result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module on_off_significance
    import on_off_pkg::*;
#(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COUNT_BITS-1:0] i_on_count,
    input  logic [COUNT_BITS-1:0] i_off_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [RATIO_BITS-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [SIG_BITS-1:0]   o_significance,
    output logic                  o_status
);

    localparam int LF  = ((55 - COUNT_BITS) < 30) ? (55 - COUNT_BITS) : 30;
    localparam int EW  = 6;
    localparam int LW  = EW + LF;
    localparam int DW  = LW + 1;
    localparam int SPL = 18;
    localparam int SH  = LF + 30 - 2 * FRAC_BITS;
    localparam int NSQ = 32;
    localparam int LAT = LF + 45;
    localparam int CB  = COUNT_BITS;

    logic                  r_busy;
    logic [RATIO_BITS-1:0] r_ratio;
    logic                  accept;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_ratio <= RATIO_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_ratio <= i_cfg_data;
            end
        end
    end

    // Stage 1: input register.
    logic          r1_v;
    logic [CB-1:0] r1_non, r1_noff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= accept;
        if (accept) begin
            r1_non  <= i_on_count;
            r1_noff <= i_off_count;
        end
    end

    // Stage 2: products for the logarithm arguments and the sign test.
    logic                  r2_v, r2_z;
    logic [CB-1:0]         r2_non, r2_noff;
    logic [63:0]           r2_x [4];
    logic [63:0]           r2_pa, r2_ns;
    logic [RATIO_BITS-1:0] n_a;
    logic [RATIO_BITS:0]   n_ap1;
    logic [CB:0]           n_sum;

    always_comb begin
        n_a   = (r_ratio == '0) ? RATIO_BITS'(1) : r_ratio;
        n_ap1 = {1'b0, n_a} + ((RATIO_BITS+1)'(1) << FRAC_BITS);
        n_sum = {1'b0, r1_non} + {1'b0, r1_noff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_z    <= (r1_non == '0) && (r1_noff == '0);
        r2_non  <= r1_non;
        r2_noff <= r1_noff;
        r2_x[0] <= 64'(r1_non) * 64'(n_ap1);
        r2_x[1] <= 64'(n_a) * 64'(n_sum);
        r2_x[2] <= 64'(r1_noff) * 64'(n_ap1);
        r2_x[3] <= 64'(n_sum) << FRAC_BITS;
        r2_pa   <= 64'(n_a) * 64'(r1_noff);
        r2_ns   <= 64'(r1_non) << FRAC_BITS;
    end

    // Stage 3: leading one of each argument, and the sign.
    logic          r3_v, r3_z, r3_pos;
    logic [CB-1:0] r3_non, r3_noff;
    logic [63:0]   r3_x [4];
    logic [EW-1:0] r3_e [4];
    logic [63:0]   n_x  [4];
    logic [EW-1:0] n_e  [4];

    always_comb begin
        for (int u = 0; u < 4; u++) begin
            n_x[u] = (r2_x[u] == '0) ? 64'd1 : r2_x[u];
            n_e[u] = '0;
            for (int i = 0; i < 64; i++) begin
                if (n_x[u][i]) n_e[u] = EW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_z    <= r2_z;
        r3_pos  <= r2_ns > r2_pa;
        r3_non  <= r2_non;
        r3_noff <= r2_noff;
        for (int u = 0; u < 4; u++) begin
            r3_x[u] <= n_x[u];
            r3_e[u] <= n_e[u];
        end
    end

    // Logarithm stages: entry 0 holds the normalised mantissa, each later
    // entry squares it once and yields one fraction bit.
    logic          r_lv   [LF+1];
    logic          r_lz   [LF+1];
    logic          r_lpos [LF+1];
    logic [CB-1:0] r_lnon [LF+1];
    logic [CB-1:0] r_lnoff[LF+1];
    logic [31:0]   r_lm   [LF+1][4];
    logic [LW-1:0] r_lr   [LF+1][4];
    logic [63:0]   n_sh   [4];

    always_comb begin
        for (int u = 0; u < 4; u++) begin
            n_sh[u] = r3_x[u] << (6'd63 - r3_e[u]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lv[0] <= 1'b0;
        else          r_lv[0] <= r3_v;
        r_lz[0]    <= r3_z;
        r_lpos[0]  <= r3_pos;
        r_lnon[0]  <= r3_non;
        r_lnoff[0] <= r3_noff;
        for (int u = 0; u < 4; u++) begin
            r_lm[0][u] <= n_sh[u][63:32];
            r_lr[0][u] <= {r3_e[u], {LF{1'b0}}};
        end
    end

    for (genvar k = 1; k <= LF; k++) begin : g_log
        logic [63:0] n_sq [4];
        logic [31:0] n_m  [4];
        logic [LW-1:0] n_r [4];

        always_comb begin
            for (int u = 0; u < 4; u++) begin
                n_sq[u] = 64'(r_lm[k-1][u]) * 64'(r_lm[k-1][u]);
                n_r[u]  = r_lr[k-1][u];
                if (n_sq[u][63]) begin
                    n_m[u]        = n_sq[u][63:32];
                    n_r[u][LF-k]  = 1'b1;
                end else begin
                    n_m[u] = n_sq[u][62:31];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_lv[k] <= 1'b0;
            else          r_lv[k] <= r_lv[k-1];
            r_lz[k]    <= r_lz[k-1];
            r_lpos[k]  <= r_lpos[k-1];
            r_lnon[k]  <= r_lnon[k-1];
            r_lnoff[k] <= r_lnoff[k-1];
            for (int u = 0; u < 4; u++) begin
                r_lm[k][u] <= n_m[u];
                r_lr[k][u] <= n_r[u];
            end
        end
    end

    // Log ratio differences.
    logic                 r5_v, r5_z, r5_pos;
    logic [CB-1:0]        r5_non, r5_noff;
    logic signed [DW-1:0] r5_don, r5_doff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r_lv[LF];
        r5_z    <= r_lz[LF];
        r5_pos  <= r_lpos[LF];
        r5_non  <= r_lnon[LF];
        r5_noff <= r_lnoff[LF];
        r5_don  <= $signed({1'b0, r_lr[LF][0]}) - $signed({1'b0, r_lr[LF][1]});
        r5_doff <= $signed({1'b0, r_lr[LF][2]}) - $signed({1'b0, r_lr[LF][3]});
    end

    // Count times log ratio, as two partial products per term.
    logic                         r6_v, r6_z, r6_pos;
    logic [CB+SPL-1:0]            r6_plon, r6_ploff;
    logic signed [CB+DW-SPL:0]    r6_phon, r6_phoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else          r6_v <= r5_v;
        r6_z     <= r5_z;
        r6_pos   <= r5_pos;
        r6_plon  <= r5_non * r5_don[SPL-1:0];
        r6_ploff <= r5_noff * r5_doff[SPL-1:0];
        r6_phon  <= $signed({1'b0, r5_non}) * $signed(r5_don[DW-1:SPL]);
        r6_phoff <= $signed({1'b0, r5_noff}) * $signed(r5_doff[DW-1:SPL]);
    end

    logic               r7_v, r7_z, r7_pos;
    logic signed [63:0] r7_ton, r7_toff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else          r7_v <= r6_v;
        r7_z    <= r6_z;
        r7_pos  <= r6_pos;
        r7_ton  <= (64'(r6_phon) <<< SPL) + $signed(64'(r6_plon));
        r7_toff <= (64'(r6_phoff) <<< SPL) + $signed(64'(r6_ploff));
    end

    logic               r8_v, r8_z, r8_pos;
    logic signed [63:0] r8_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else          r8_v <= r7_v;
        r8_z   <= r7_z;
        r8_pos <= r7_pos;
        r8_t   <= r7_ton + r7_toff;
    end

    logic        r9_v, r9_z, r9_pos;
    logic [63:0] r9_tabs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else          r9_v <= r8_v;
        r9_z    <= r8_z;
        r9_pos  <= r8_pos;
        r9_tabs <= r8_t[63] ? (64'd0 - 64'(r8_t)) : 64'(r8_t);
    end

    // Scaling by two ln 2, in two halves.
    logic        r10_v, r10_z, r10_pos;
    logic [63:0] r10_ua, r10_ub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else          r10_v <= r9_v;
        r10_z   <= r9_z;
        r10_pos <= r9_pos;
        r10_ua  <= 64'(r9_tabs[63:32]) * 64'(TWO_LN2);
        r10_ub  <= 64'(r9_tabs[31:0]) * 64'(TWO_LN2);
    end

    logic        r11_v, r11_z, r11_pos;
    logic [63:0] r11_u;
    logic [31:0] r11_ubl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_v <= 1'b0;
        else          r11_v <= r10_v;
        r11_z   <= r10_z;
        r11_pos <= r10_pos;
        r11_u   <= r10_ua + (r10_ub >> 32);
        r11_ubl <= r10_ub[31:0];
    end

    // Square root stages: entry 0 holds the radicand.
    logic        r_sv  [NSQ+1];
    logic        r_sz0 [NSQ+1];
    logic        r_spos[NSQ+1];
    logic [63:0] r_sz  [NSQ+1];
    logic [63:0] r_sr  [NSQ+1];
    logic [63:0] n_z;

    if (SH >= 32) begin : g_shr
        assign n_z = r11_u >> (SH - 32);
    end else begin : g_shl
        always_comb begin
            if ((r11_u >> (32 + SH)) != '0) begin
                n_z = '1;
            end else begin
                n_z = (r11_u << (32 - SH)) | 64'(r11_ubl >> SH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else          r_sv[0] <= r11_v;
        r_sz0[0]  <= r11_z;
        r_spos[0] <= r11_pos;
        r_sz[0]   <= n_z;
        r_sr[0]   <= '0;
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_t;

        assign n_t = r_sr[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else          r_sv[k+1] <= r_sv[k];
            r_sz0[k+1]  <= r_sz0[k];
            r_spos[k+1] <= r_spos[k];
            if (r_sz[k] >= n_t) begin
                r_sz[k+1] <= r_sz[k] - n_t;
                r_sr[k+1] <= (r_sr[k] >> 1) + BIT;
            end else begin
                r_sz[k+1] <= r_sz[k];
                r_sr[k+1] <= r_sr[k] >> 1;
            end
        end
    end

    // Output register: sign, saturation and the empty case.
    logic                r_ov, r_opos;
    logic [SIG_BITS-1:0] r_osig;
    t_status             r_ost;
    logic [63:0]         n_res;

    assign n_res = r_sr[NSQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_sv[NSQ];
        r_opos <= r_spos[NSQ] && !r_sz0[NSQ];
        if (r_sz0[NSQ]) begin
            r_osig <= '0;
            r_ost  <= STATUS_EMPTY;
        end else if (r_spos[NSQ]) begin
            r_osig <= (n_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : n_res[31:0];
            r_ost  <= STATUS_VALID;
        end else begin
            r_osig <= (n_res > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - n_res[31:0]);
            r_ost  <= STATUS_VALID;
        end
    end

    assign o_valid        = r_ov;
    assign o_significance = r_osig;
    assign o_status       = r_ost;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("result strobe missing after a transfer");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_EMPTY) |-> (o_significance == '0))
        else $error("empty result carries a nonzero significance");

    a_pos_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_opos) |-> !o_significance[SIG_BITS-1])
        else $error("positive excess gave a negative significance");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_sv[NSQ]) && $past(r_lv[LF], NSQ + 9))
        else $error("result strobe without an item in the pipeline");

endmodule
// ----------------------------------------------------------------------------
